// File: rtl/core/sat_pkg.sv
// ============================================================================
// sat_pkg
// Shared types and constants for the security-association table with a
// per-association anti-replay window.
// ============================================================================
`default_nettype none

package sat_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SEQ_W  = 32;
    localparam int SPI_W  = 32;
    localparam int WIN_W  = 32;
    localparam int ENTRY_W = SEQ_W + WIN_W;

    localparam logic [SPI_W-1:0] SPI_START_RST = 32'd256;

    localparam logic [2:0] ST_ACCEPT = 3'd0;
    localparam logic [2:0] ST_REPLAY = 3'd1;
    localparam logic [2:0] ST_NOSA   = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic REG_SPI_START = 1'b0;

    typedef enum logic [1:0] {
        CMD_CHECK  = 2'd0,
        CMD_CREATE = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    typedef struct packed {
        logic              set;
        logic [SLOT_W-1:0] set_slot;
        logic [SPI_W-1:0]  set_spi;
        logic              clr;
        logic [SLOT_W-1:0] clr_slot;
    } t_tbl_upd;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              free;
        logic [SLOT_W-1:0] free_slot;
    } t_tbl_look;

    typedef struct packed {
        logic             accept;
        logic [SEQ_W-1:0] high;
        logic [WIN_W-1:0] window;
    } t_rpl;

endpackage

`default_nettype wire

// File: rtl/core/sat_ram.sv
// ============================================================================
// sat_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ============================================================================
`default_nettype none

module sat_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sat_match.sv
// ============================================================================
// sat_match
// Slot valid bits and SPI tags with a parallel SPI match and a lowest free
// slot search.
// ============================================================================
`default_nettype none

module sat_match (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [sat_pkg::SPI_W-1:0] i_spi,
    input  wire sat_pkg::t_tbl_upd        i_upd,
    output sat_pkg::t_tbl_look            o_look
);

    logic [sat_pkg::SLOTS-1:0] r_valid;
    logic [sat_pkg::SPI_W-1:0] r_tag [sat_pkg::SLOTS];
    logic [sat_pkg::SLOTS-1:0] hit_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_upd.clr) begin
                r_valid[i_upd.clr_slot] <= 1'b0;
            end
            if (i_upd.set) begin
                r_valid[i_upd.set_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.set) begin
            r_tag[i_upd.set_slot] <= i_upd.set_spi;
        end
    end

    always_comb begin
        for (int s = 0; s < sat_pkg::SLOTS; s++) begin
            hit_vec[s] = r_valid[s] && (r_tag[s] == i_spi);
        end
    end

    always_comb begin
        o_look = '0;
        for (int s = sat_pkg::SLOTS - 1; s >= 0; s--) begin
            if (hit_vec[s]) begin
                o_look.hit      = 1'b1;
                o_look.hit_slot = sat_pkg::SLOT_W'(s);
            end
            if (!r_valid[s]) begin
                o_look.free      = 1'b1;
                o_look.free_slot = sat_pkg::SLOT_W'(s);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sat_replay.sv
// ============================================================================
// sat_replay
// Sliding-window replay rule: updates the highest sequence number and the
// window of one association for one packet.
// ============================================================================
`default_nettype none

module sat_replay (
    input  wire logic [sat_pkg::SEQ_W-1:0] i_seq,
    input  wire logic [sat_pkg::SEQ_W-1:0] i_high,
    input  wire logic [sat_pkg::WIN_W-1:0] i_window,
    output sat_pkg::t_rpl                  o_rpl
);

    logic [sat_pkg::SEQ_W-1:0] ahead;
    logic [sat_pkg::SEQ_W-1:0] behind;
    logic                      newer;

    assign ahead  = i_seq - i_high;
    assign behind = i_high - i_seq;
    assign newer  = i_seq > i_high;

    always_comb begin
        o_rpl.accept = 1'b0;
        o_rpl.high   = i_high;
        o_rpl.window = i_window;
        if (newer) begin
            o_rpl.accept = 1'b1;
            o_rpl.high   = i_seq;
            if (ahead[sat_pkg::SEQ_W-1:5] != '0) begin
                o_rpl.window = {{(sat_pkg::WIN_W-1){1'b0}}, 1'b1};
            end else begin
                o_rpl.window = (i_window << ahead[4:0]) | sat_pkg::WIN_W'(1);
            end
        end else if (behind[sat_pkg::SEQ_W-1:5] == '0 && !i_window[behind[4:0]]) begin
            o_rpl.accept = 1'b1;
            o_rpl.window = i_window | (sat_pkg::WIN_W'(1) << behind[4:0]);
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/ipsec_sa_table_antireplay.sv
// ============================================================================
// ipsec_sa_table_antireplay
// Inbound security-association table with a 32-bit anti-replay window per
// association, plus create and remove commands.
// ============================================================================
// The SPI match and free-slot search run in the accept cycle and address the
// window memory, whose registered read returns the highest sequence number
// and window in the next cycle; the result is computed from them and written
// back when the transaction finishes. The block takes one transaction at a
// time, and a finished result waits in the output register while the next
// transaction is accepted. There is no clearing pass after reset.
`default_nettype none

module ipsec_sa_table_antireplay (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [31:0] i_spi,
    input  wire logic [31:0] i_seq_number,
    input  wire logic [2:0]  i_slot_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [2:0]       o_slot_found,
    output logic [31:0]      o_spi_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    sat_pkg::t_state    r_state, n_state;
    sat_pkg::t_tbl_look look;
    sat_pkg::t_tbl_upd  upd;
    sat_pkg::t_rpl      rpl;

    logic [1:0]                  r_cmd;
    logic [sat_pkg::SPI_W-1:0]   r_spi;
    logic [sat_pkg::SEQ_W-1:0]   r_seq;
    logic [2:0]                  r_idx;
    logic                        r_hit;
    logic                        r_free;
    logic [sat_pkg::SLOT_W-1:0]  r_slot;

    logic [sat_pkg::SPI_W-1:0]   r_spi_start;
    logic [sat_pkg::SPI_W-1:0]   r_next_spi;

    logic                        r_out_valid;
    logic [2:0]                  r_status, n_status;
    logic [2:0]                  r_slot_found, n_slot_found;
    logic [31:0]                 r_spi_out, n_spi_out;

    logic                        accept;
    logic                        finish;
    logic                        cfg_wr;
    logic                        ram_we;
    logic [sat_pkg::ENTRY_W-1:0] ram_wdata;
    logic [sat_pkg::ENTRY_W-1:0] ram_rdata;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == sat_pkg::REG_SPI_START);
    assign prdata  = (paddr[2] == sat_pkg::REG_SPI_START) ? r_spi_start : '0;

    assign o_stall = (r_state != sat_pkg::S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign finish  = (r_state == sat_pkg::S_EXEC) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sat_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = sat_pkg::S_EXEC;
                end
            end
            sat_pkg::S_EXEC: begin
                if (finish) begin
                    n_state = sat_pkg::S_IDLE;
                end
            end
            default: n_state = sat_pkg::S_IDLE;
        endcase
    end

    sat_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_spi   (i_spi),
        .i_upd   (upd),
        .o_look  (look)
    );

    sat_ram #(
        .WIDTH (sat_pkg::ENTRY_W),
        .DEPTH (sat_pkg::SLOTS)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (look.hit_slot),
        .o_rdata (ram_rdata)
    );

    sat_replay u_replay (
        .i_seq    (r_seq),
        .i_high   (ram_rdata[sat_pkg::ENTRY_W-1:sat_pkg::WIN_W]),
        .i_window (ram_rdata[sat_pkg::WIN_W-1:0]),
        .o_rpl    (rpl)
    );

    always_comb begin
        upd          = '0;
        upd.set_slot = r_slot;
        upd.set_spi  = r_next_spi;
        upd.clr_slot = sat_pkg::SLOT_W'(r_idx);
        ram_we       = 1'b0;
        ram_wdata    = '0;
        n_status     = sat_pkg::ST_DONE;
        n_slot_found = '0;
        n_spi_out    = '0;
        unique case (r_cmd)
            sat_pkg::CMD_CHECK: begin
                if (r_hit) begin
                    n_status     = rpl.accept ? sat_pkg::ST_ACCEPT : sat_pkg::ST_REPLAY;
                    n_slot_found = 3'(r_slot);
                    n_spi_out    = r_spi;
                    ram_we       = finish && rpl.accept;
                    ram_wdata    = {rpl.high, rpl.window};
                end else begin
                    n_status = sat_pkg::ST_NOSA;
                end
            end
            sat_pkg::CMD_CREATE: begin
                if (r_free) begin
                    n_slot_found = 3'(r_slot);
                    n_spi_out    = r_next_spi;
                    upd.set      = finish;
                    ram_we       = finish;
                end else begin
                    n_status = sat_pkg::ST_FULL;
                end
            end
            sat_pkg::CMD_REMOVE: begin
                upd.clr = finish && (32'(r_idx) < 32'(sat_pkg::SLOTS));
            end
            default: begin
                n_status = sat_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sat_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_spi_start <= sat_pkg::SPI_START_RST;
            r_next_spi  <= sat_pkg::SPI_START_RST;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                r_spi_start <= pwdata;
                r_next_spi  <= pwdata;
            end else if (upd.set) begin
                r_next_spi <= r_next_spi + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_spi  <= i_spi;
            r_seq  <= i_seq_number;
            r_idx  <= i_slot_index;
            r_hit  <= look.hit;
            r_free <= look.free;
            r_slot <= (i_command == sat_pkg::CMD_CHECK) ? look.hit_slot : look.free_slot;
        end
        if (finish) begin
            r_status     <= n_status;
            r_slot_found <= n_slot_found;
            r_spi_out    <= n_spi_out;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_found = r_slot_found;
    assign o_spi_out    = r_spi_out;

endmodule

`default_nettype wire

// File: rtl/core/sat_checker.sv
// ============================================================================
// sat_checker
// Port-level checks for the security-association table, bound to the top.
// ============================================================================
`default_nettype none

module sat_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_status,
    input wire logic [2:0]  o_slot_found,
    input wire logic [31:0] o_spi_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_spi_out))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= sat_pkg::ST_DONE)
        else $error("status code out of range");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == sat_pkg::ST_NOSA || o_status == sat_pkg::ST_FULL)
        |-> o_slot_found == 3'd0 && o_spi_out == 32'd0)
        else $error("miss or full result carries a slot or SPI");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second transaction accepted while busy");

endmodule

bind ipsec_sa_table_antireplay sat_checker u_sat_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_slot_found (o_slot_found),
    .o_spi_out    (o_spi_out)
);

`default_nettype wire
